/* rtl/ctph_pkg.sv */
// ----------------------------------------------------------------------------
// ctph_pkg
// Shared types and constants for the capped token pool holder set.
// ----------------------------------------------------------------------------
package ctph_pkg;

	localparam int DEF_POOL_COUNT  = 2;
	localparam int DEF_MAX_HOLDERS = 8;

	localparam int MODE_W   = 2;
	localparam int KEY_W    = 2;
	localparam int ID_W     = 16;
	localparam int STATUS_W = 3;
	localparam int HCNT_W   = 4;
	localparam int CAP_W    = 4;
	localparam int CFG_IDX_W = 2;

	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 8;

	localparam logic [CAP_W-1:0] CAP_ZERO_RESET = 4'd6;
	localparam logic [CAP_W-1:0] CAP_ONE_RESET  = 4'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAP_ZERO = 2'd0,
		CFG_CAP_ONE  = 2'd1
	} cfg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_GRANT   = 2'd0,
		MODE_RETRACT = 2'd1,
		MODE_QUERY   = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE       = 3'd0,
		ST_ALREADY    = 3'd1,
		ST_FULL       = 3'd2,
		ST_UNKNOWN    = 3'd3,
		ST_NOT_HOLDER = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic match;
		logic commit;
	} ctph_cmd_t;

endpackage

/* rtl/ctph_ctrl.sv */
// ----------------------------------------------------------------------------
// ctph_ctrl
// Sequencer: load, match, commit; owns both handshakes.
// ----------------------------------------------------------------------------
module ctph_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output ctph_pkg::ctph_cmd_t cmd
);
	import ctph_pkg::*;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (s_tvalid) state_d = S_MATCH;
			S_MATCH: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = s_tvalid ? S_MATCH : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE:  s_tready = 1'b1;
			S_MATCH: cmd.match = 1'b1;
			S_DONE: begin
				cmd.commit = out_free;
				s_tready   = out_free;
			end
			default: ;
		endcase
		cmd.load = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

/* rtl/ctph_dp.sv */
// ----------------------------------------------------------------------------
// ctph_dp
// Holder store, per-pool counts and caps, slot match and result register.
// ----------------------------------------------------------------------------
module ctph_dp #(
	parameter int POOL_COUNT  = ctph_pkg::DEF_POOL_COUNT,
	parameter int MAX_HOLDERS = ctph_pkg::DEF_MAX_HOLDERS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ctph_pkg::ctph_cmd_t             cmd,
	input  logic [ctph_pkg::MODE_W-1:0]     mode,
	input  logic [ctph_pkg::KEY_W-1:0]      pool_key,
	input  logic [ctph_pkg::ID_W-1:0]       requester_id,
	input  logic                            cfg_we,
	input  logic [ctph_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ctph_pkg::CAP_W-1:0]      cfg_data,
	output logic                            ok,
	output logic [ctph_pkg::STATUS_W-1:0]   status,
	output logic [ctph_pkg::HCNT_W-1:0]     holder_count
);
	import ctph_pkg::*;

	localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
	localparam int CW = $clog2(MAX_HOLDERS + 1);
	localparam int XW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [KEY_W-1:0] POOLS_L = KEY_W'(POOL_COUNT);
	localparam logic [XW-1:0]    MAX_L   = XW'(MAX_HOLDERS);

	logic [ID_W-1:0]        owner_q [POOL_COUNT][MAX_HOLDERS];
	logic [MAX_HOLDERS-1:0] used_q  [POOL_COUNT];
	logic [CW-1:0]          count_q [POOL_COUNT];
	logic [CAP_W-1:0]       cap_zero_q, cap_one_q;

	logic [MODE_W-1:0]      mode_q;
	logic [KEY_W-1:0]       pool_q;
	logic [ID_W-1:0]        id_q;

	logic [MAX_HOLDERS-1:0] hit_s1, free_s1;

	logic                   known;
	logic [PW-1:0]          sel;
	logic [MAX_HOLDERS-1:0] first_free;
	logic                   hit_any, full;
	logic [CAP_W-1:0]       cap_sel;
	logic [CW-1:0]          cnt_cur, cnt_next;
	logic                   do_grant, do_retract, ok_d;
	status_t                status_d;

	assign known = (pool_q < POOLS_L);
	assign sel   = known ? pool_q[PW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			pool_q <= pool_key;
			id_q   <= requester_id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			for (int s = 0; s < MAX_HOLDERS; s++)
				hit_s1[s] <= used_q[sel][s] && (owner_q[sel][s] == id_q);
			free_s1 <= ~used_q[sel];
		end
	end

	assign first_free = free_s1 & (~free_s1 + MAX_HOLDERS'(1));
	assign hit_any    = |hit_s1;
	assign cnt_cur    = count_q[sel];
	assign cap_sel    = (sel == '0) ? cap_zero_q : cap_one_q;
	assign full       = (XW'(cnt_cur) >= XW'(cap_sel)) || (XW'(cnt_cur) >= MAX_L);

	always_comb begin
		do_grant   = 1'b0;
		do_retract = 1'b0;
		ok_d       = 1'b0;
		status_d   = ST_UNKNOWN;
		cnt_next   = cnt_cur;
		if (known) begin
			case (mode_t'(mode_q))
				MODE_GRANT: begin
					if (hit_any) status_d = ST_ALREADY;
					else if (full) status_d = ST_FULL;
					else begin
						do_grant = 1'b1;
						ok_d     = 1'b1;
						status_d = ST_DONE;
						cnt_next = cnt_cur + CW'(1);
					end
				end
				MODE_RETRACT: begin
					if (hit_any) begin
						do_retract = 1'b1;
						ok_d       = 1'b1;
						status_d   = ST_DONE;
						cnt_next   = cnt_cur - CW'(1);
					end else status_d = ST_NOT_HOLDER;
				end
				default: begin
					ok_d     = hit_any;
					status_d = hit_any ? ST_DONE : ST_NOT_HOLDER;
				end
			endcase
		end else begin
			cnt_next = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && do_grant) begin
			for (int s = 0; s < MAX_HOLDERS; s++)
				if (first_free[s]) owner_q[sel][s] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < POOL_COUNT; p++) begin
				used_q[p]  <= '0;
				count_q[p] <= '0;
			end
			cap_zero_q <= CAP_ZERO_RESET;
			cap_one_q  <= CAP_ONE_RESET;
		end else begin
			if (cmd.commit && known) begin
				if (do_grant) used_q[sel] <= used_q[sel] | first_free;
				if (do_retract) used_q[sel] <= used_q[sel] & ~hit_s1;
				count_q[sel] <= cnt_next;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CAP_ZERO: cap_zero_q <= cfg_data;
					CFG_CAP_ONE:  cap_one_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			ok           <= ok_d;
			status       <= status_d;
			holder_count <= HCNT_W'(cnt_next);
		end
	end

endmodule

/* rtl/capped_token_pool_holder_set.sv */
// ----------------------------------------------------------------------------
// capped_token_pool_holder_set
// Two capped token pools, each tracking the set of requester IDs holding it.
// ----------------------------------------------------------------------------
// Each item is registered on acceptance, matched against the slots in the match state,
// then written to the result register in the commit state; no new item is taken while matching.
// A new item is taken in the commit cycle once the result register is free.
// Reset: pools empty, caps 6 and 3; no clearing pass, ready right after reset.
module capped_token_pool_holder_set #(
	parameter int POOL_COUNT  = ctph_pkg::DEF_POOL_COUNT,
	parameter int MAX_HOLDERS = ctph_pkg::DEF_MAX_HOLDERS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ctph_pkg::S_DATA_W-1:0]    s_tdata,   // mode, pool_key, requester_id
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ctph_pkg::M_DATA_W-1:0]    m_tdata,   // ok, status, holder_count
	input  logic                             cfg_we,
	input  logic [ctph_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ctph_pkg::CAP_W-1:0]       cfg_data
);
	import ctph_pkg::*;

	ctph_cmd_t           cmd;
	logic                ok;
	logic [STATUS_W-1:0] status;
	logic [HCNT_W-1:0]   holder_count;

	ctph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ctph_dp #(
		.POOL_COUNT  (POOL_COUNT),
		.MAX_HOLDERS (MAX_HOLDERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (s_tdata[1:0]),
		.pool_key     (s_tdata[3:2]),
		.requester_id (s_tdata[19:4]),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ok           (ok),
		.status       (status),
		.holder_count (holder_count)
	);

	assign m_tdata = {holder_count, status, ok};

endmodule

/* rtl/ctph_checker.sv */
// ----------------------------------------------------------------------------
// ctph_checker
// Port-level checks for the capped token pool holder set.
// ----------------------------------------------------------------------------
module ctph_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ctph_pkg::M_DATA_W-1:0] m_tdata
);
	import ctph_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == ST_DONE)))
		else $error("ok disagrees with status");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[3:1] == ST_UNKNOWN) |-> (m_tdata[7:4] == '0))
		else $error("unknown key reported holders");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted during match cycle");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:1] == ST_DONE || m_tdata[3:1] == ST_ALREADY ||
			m_tdata[3:1] == ST_FULL || m_tdata[3:1] == ST_UNKNOWN ||
			m_tdata[3:1] == ST_NOT_HOLDER))
		else $error("status code out of range");

endmodule

bind capped_token_pool_holder_set ctph_checker u_ctph_checker (.*);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the capped token pool holder set. A queue-fed
// driver sends grant, retract and query requests over the input stream while
// a scoreboard tracks holders and caps per pool and checks each reply. Caps
// change only while the block is drained; idling and stalls vary by phase.
// ----------------------------------------------------------------------------
module tb;
	import ctph_pkg::*;

	localparam int POOLS        = DEF_POOL_COUNT;
	localparam int SLOTS        = DEF_MAX_HOLDERS;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4;

	localparam logic [MODE_W-1:0]    MODE_QUERY_ALT = 2'd3;
	localparam logic [KEY_W-1:0]     KEY_POOL_ZERO  = 2'd0;
	localparam logic [KEY_W-1:0]     KEY_POOL_ONE   = 2'd1;
	localparam logic [KEY_W-1:0]     KEY_BAD_LO     = 2'd2;
	localparam logic [KEY_W-1:0]     KEY_BAD_HI     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI   = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [KEY_W-1:0]  key;
		logic [MODE_W-1:0] mode;
	} pool_req_t;

	typedef struct {
		logic              ok;
		status_t           status;
		logic [HCNT_W-1:0] count;
	} pool_reply_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata   = '0;   // mode, pool_key, requester_id
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;          // ok, status, holder_count
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CAP_W-1:0]     cfg_data  = '0;

	pool_req_t   request_q[$];
	pool_reply_t reply_q[$];
	pool_reply_t want;

	logic [ID_W-1:0]  owner_id [POOLS][SLOTS];
	logic             held     [POOLS][SLOTS];
	logic [CAP_W-1:0] pool_cap [POOLS];

	int src_idle_pct  = 0;
	int dst_stall_pct = 0;
	int mismatches    = 0;
	int cycles        = 0;

	logic [ID_W-1:0] hot_ids [10] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h00FF,
		16'hFF00, 16'h5555, 16'hAAAA, 16'h1234, 16'h4321};

	capped_token_pool_holder_set dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void admit_request(pool_req_t r);
		pool_reply_t rep;
		int hit;
		int used_cnt;
		int limit;
		bit placed;
		rep.ok     = 1'b0;
		rep.status = ST_UNKNOWN;
		rep.count  = '0;
		if (r.key < POOLS) begin
			hit      = -1;
			used_cnt = 0;
			placed   = 1'b0;
			for (int s = 0; s < SLOTS; s++) begin
				if (held[r.key][s]) begin
					used_cnt++;
					if (owner_id[r.key][s] == r.id && hit < 0)
						hit = s;
				end
			end
			limit      = (int'(pool_cap[r.key]) > SLOTS) ? SLOTS : int'(pool_cap[r.key]);
			rep.status = ST_NOT_HOLDER;
			if (r.mode == MODE_GRANT) begin
				if (hit >= 0) begin
					rep.status = ST_ALREADY;
				end else if (used_cnt >= limit) begin
					rep.status = ST_FULL;
				end else begin
					// take the lowest free slot
					for (int s = 0; s < SLOTS; s++) begin
						if (!held[r.key][s] && !placed) begin
							held[r.key][s]     = 1'b1;
							owner_id[r.key][s] = r.id;
							placed             = 1'b1;
						end
					end
					used_cnt++;
					rep.ok     = 1'b1;
					rep.status = ST_DONE;
				end
			end else if (r.mode == MODE_RETRACT) begin
				if (hit >= 0) begin
					held[r.key][hit] = 1'b0;
					used_cnt--;
					rep.ok     = 1'b1;
					rep.status = ST_DONE;
				end
			end else if (hit >= 0) begin
				rep.ok     = 1'b1;
				rep.status = ST_DONE;
			end
			rep.count = HCNT_W'(used_cnt);
		end
		reply_q.push_back(rep);
	endfunction

	task automatic queue_req(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
		logic [ID_W-1:0] id);
		pool_req_t r;
		r.mode = mode;
		r.key  = key;
		r.id   = id;
		request_q.push_back(r);
	endtask

	task automatic queue_random(int n);
		int roll;
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0] id;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 40)
				mode = MODE_GRANT;
			else if (roll < 65)
				mode = MODE_RETRACT;
			else if (roll < 92)
				mode = MODE_QUERY;
			else
				mode = MODE_QUERY_ALT;
			if ($urandom_range(99) < 10)
				key = ($urandom_range(1) != 0) ? KEY_BAD_HI : KEY_BAD_LO;
			else
				key = ($urandom_range(1) != 0) ? KEY_POOL_ONE : KEY_POOL_ZERO;
			if ($urandom_range(99) < 80)
				id = hot_ids[$urandom_range(9)];
			else
				id = ID_W'($urandom_range(65535));
			queue_req(mode, key, id);
		end
	endtask

	task automatic wait_idle();
		while (request_q.size() != 0 || s_tvalid || reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cap(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CAP_ZERO)
			pool_cap[0] = val;
		else if (idx == CFG_CAP_ONE)
			pool_cap[1] = val;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				admit_request(pool_req_t'(s_tdata[$bits(pool_req_t)-1:0]));
			if (!s_tvalid || s_tready) begin
				if (request_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= S_DATA_W'(request_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					$error("result item with no request outstanding: %h", m_tdata);
					mismatches++;
				end else begin
					want = reply_q.pop_front();
					if (m_tdata[0] !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, m_tdata[0]);
						mismatches++;
					end
					if (m_tdata[3:1] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tdata[3:1]);
						mismatches++;
					end
					if (m_tdata[7:4] !== want.count) begin
						$error("holder_count: expected %0d, got %0d", want.count,
							m_tdata[7:4]);
						mismatches++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= dst_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		for (int p = 0; p < POOLS; p++)
			for (int s = 0; s < SLOTS; s++) begin
				held[p][s]     = 1'b0;
				owner_id[p][s] = '0;
			end
		pool_cap[0] = CAP_ZERO_RESET;
		pool_cap[1] = CAP_ONE_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill pool one past its cap, then exercise every reply code
		queue_req(MODE_GRANT, KEY_POOL_ONE, 16'h0000);
		queue_req(MODE_GRANT, KEY_POOL_ONE, 16'hFFFF);
		queue_req(MODE_GRANT, KEY_POOL_ONE, 16'h1234);
		queue_req(MODE_GRANT, KEY_POOL_ONE, 16'hA5A5);
		queue_req(MODE_GRANT, KEY_POOL_ONE, 16'hFFFF);
		queue_req(MODE_QUERY, KEY_POOL_ONE, 16'hFFFF);
		queue_req(MODE_QUERY_ALT, KEY_POOL_ONE, 16'h1234);
		queue_req(MODE_QUERY, KEY_POOL_ONE, 16'h5A5A);
		queue_req(MODE_RETRACT, KEY_POOL_ONE, 16'h0000);
		queue_req(MODE_RETRACT, KEY_POOL_ONE, 16'h0000);
		queue_req(MODE_GRANT, KEY_POOL_ONE, 16'hA5A5);
		queue_req(MODE_QUERY_ALT, KEY_POOL_ONE, 16'h0000);
		queue_req(MODE_RETRACT, KEY_POOL_ONE, 16'hA5A5);
		queue_req(MODE_GRANT, KEY_BAD_LO, 16'hFFFF);
		queue_req(MODE_RETRACT, KEY_BAD_HI, 16'hFFFF);
		queue_req(MODE_QUERY_ALT, KEY_BAD_HI, 16'h0000);
		queue_req(MODE_QUERY, KEY_BAD_LO, 16'h5A5A);
		queue_req(MODE_GRANT, KEY_POOL_ZERO, 16'hFFFF);
		queue_req(MODE_GRANT, KEY_POOL_ZERO, 16'h0000);
		queue_req(MODE_RETRACT, KEY_POOL_ZERO, 16'h1234);
		queue_req(MODE_QUERY, KEY_POOL_ZERO, 16'hFFFF);
		queue_req(MODE_GRANT, KEY_POOL_ZERO, 16'h8000);
		queue_req(MODE_GRANT, KEY_POOL_ZERO, 16'h7FFF);
		queue_req(MODE_GRANT, KEY_POOL_ZERO, 16'hFFFF);
		wait_idle();

		// cap above slot count and cap of zero; spare indexes must be ignored
		write_cap(CFG_CAP_ZERO, 4'd15);
		write_cap(CFG_CAP_ONE, 4'd0);
		write_cap(CFG_SPARE_LO, 4'd5);
		write_cap(CFG_SPARE_HI, 4'd1);
		queue_random(120);
		wait_idle();
		queue_random(130);
		wait_idle();

		write_cap(CFG_CAP_ZERO, 4'd8);
		write_cap(CFG_CAP_ONE, 4'd8);
		src_idle_pct = 73;
		queue_random(250);
		wait_idle();

		// lower caps below the current holder counts
		write_cap(CFG_CAP_ZERO, 4'd2);
		write_cap(CFG_CAP_ONE, 4'd1);
		src_idle_pct  = 0;
		dst_stall_pct = 73;
		queue_random(250);
		wait_idle();

		src_idle_pct  = 36;
		dst_stall_pct = 36;
		for (int k = 0; k < 4; k++) begin
			write_cap(CFG_CAP_ZERO, CAP_W'($urandom_range(15)));
			write_cap(CFG_CAP_ONE, CAP_W'($urandom_range(15)));
			queue_random(80);
			wait_idle();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
